// File: rtl/core/smm_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_pkg: shared types and constants for the square matrix multiplier
// Holds the controller state type, the command bundle that runs the
// datapath, and the fixed field widths of the block.
// ----------------------------------------------------------------------------
package smm_pkg;

    // matrix_size register
    localparam int                SIZE_W     = 4;
    localparam logic [SIZE_W-1:0] SIZE_RESET = 4'd8;

    // result element: signed Q19.16, padded to whole bytes on the stream
    localparam int OUT_W       = 35;
    localparam int OUT_TDATA_W = 40;

    typedef enum logic {
        ST_LOAD,
        ST_COMPUTE
    } smm_state_t;

    // position of one product inside the sum loop
    typedef struct packed {
        logic first_k;    // first product of an element: restart the sum
        logic last_k;     // last product of an element: emit the sum
        logic last_elem;  // last element of the product matrix
    } smm_tag_t;

    typedef struct packed {
        logic     wr_en;  // store one input pair
        logic     rd_en;  // read one operand pair for a product
        smm_tag_t tag;
    } smm_cmd_t;

    // address width of an element store for a given maximum dimension
    function automatic int smm_addr_w(input int dim);
        return (dim * dim > 1) ? $clog2(dim * dim) : 1;
    endfunction

endpackage

// File: rtl/core/square_matrix_multiply.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// square_matrix_multiply: C = A * B for square n by n fixed-point matrices
// Load both matrices pair by pair over the slave stream, then stream out C.
//
// Usage:
//   - Write the dimension n (1 .. MAX_DIM) on cfg_wr_en / cfg_wr_data while
//     idle. Zero acts as 1, values above MAX_DIM act as MAX_DIM. A write also
//     drops any partly loaded pair of matrices.
//   - Send n*n transactions on s_axis, each carrying A[p] and B[p] (signed
//     Q8.8) at the same row-major position p.
//   - After the n*n-th transaction the block emits n*n elements of C on
//     m_axis in row-major order, signed Q19.16, exact; tlast marks C[n-1][n-1].
// Timing:
//   - s_axis_tready is high throughout the load phase and low while the product
//     loop issues operand reads, also while that loop is stalled.
//   - One shared multiply-accumulate issues one product per cycle while
//     the output is not stalled; each C element sums n products, which
//     pass the operand read, product and output registers in that order.
// Reset: the size returns to 8 and the load position to zero; store
//   contents are not cleared. A result held by a stalled receiver stalls
//   the whole product pipe; nothing is dropped. Loading of the next pair
//   may start while earlier results still drain.
// ----------------------------------------------------------------------------
module square_matrix_multiply
    import smm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
)
(
    input  logic                                    clk,
    input  logic                                    rst_n,
    input  logic                                    cfg_wr_en,
    input  logic [SIZE_W-1:0]                       cfg_wr_data,   // matrix_size
    input  logic                                    s_axis_tvalid,
    output logic                                    s_axis_tready,
    // bits up: a_elem, b_elem, zero fill to whole bytes
    input  logic [((2 * ELEM_BITS + 7) / 8) * 8-1:0] s_axis_tdata,
    output logic                                    m_axis_tvalid,
    input  logic                                    m_axis_tready,
    output logic [OUT_TDATA_W-1:0]                  m_axis_tdata,  // c_elem, zero fill
    output logic                                    m_axis_tlast   // last_out
);

    localparam int ADDR_W = (MAX_DIM * MAX_DIM > 1) ? $clog2(MAX_DIM * MAX_DIM) : 1;

    smm_cmd_t          cmd;
    logic              advance;
    logic [ADDR_W-1:0] wr_addr;
    logic [ADDR_W-1:0] rd_a_addr;
    logic [ADDR_W-1:0] rd_b_addr;
    logic [OUT_W-1:0]  c_elem;

    // sequencer: load count, product loop indices, size register
    smm_ctrl #(
        .MAX_DIM (MAX_DIM)
    ) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .cfg_wr_en   (cfg_wr_en),
        .cfg_wr_data (cfg_wr_data),
        .in_valid    (s_axis_tvalid),
        .in_ready    (s_axis_tready),
        .advance     (advance),
        .cmd         (cmd),
        .wr_addr     (wr_addr),
        .rd_a_addr   (rd_a_addr),
        .rd_b_addr   (rd_b_addr)
    );

    // stores, multiplier, accumulator and the output register
    smm_datapath #(
        .MAX_DIM   (MAX_DIM),
        .ELEM_BITS (ELEM_BITS)
    ) u_datapath (
        .clk       (clk),
        .rst_n     (rst_n),
        .cmd       (cmd),
        .wr_addr   (wr_addr),
        .rd_a_addr (rd_a_addr),
        .rd_b_addr (rd_b_addr),
        .wr_a      (s_axis_tdata[ELEM_BITS-1:0]),
        .wr_b      (s_axis_tdata[2*ELEM_BITS-1:ELEM_BITS]),
        .advance   (advance),
        .out_valid (m_axis_tvalid),
        .out_ready (m_axis_tready),
        .out_elem  (c_elem),
        .out_last  (m_axis_tlast)
    );

    // pad the result to whole bytes
    assign m_axis_tdata = {{(OUT_TDATA_W - OUT_W){1'b0}}, c_elem};

endmodule

// File: rtl/core/smm_ctrl.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_ctrl: load and sequencing controller
// Counts loaded pairs, then steps i, j, k over the product loop and issues
// one operand read per cycle while the datapath advances.
// ----------------------------------------------------------------------------
module smm_ctrl
    import smm_pkg::*;
#(
    parameter int MAX_DIM = 8
)
(
    input  logic                                  clk,
    input  logic                                  rst_n,
    input  logic                                  cfg_wr_en,
    input  logic [SIZE_W-1:0]                     cfg_wr_data,
    input  logic                                  in_valid,
    output logic                                  in_ready,
    input  logic                                  advance,
    output smm_cmd_t                              cmd,
    output logic [smm_addr_w(MAX_DIM)-1:0]        wr_addr,
    output logic [smm_addr_w(MAX_DIM)-1:0]        rd_a_addr,
    output logic [smm_addr_w(MAX_DIM)-1:0]        rd_b_addr
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int ADDR_W = smm_addr_w(MAX_DIM);
    localparam int CNT_W  = $clog2(DEPTH + 1);
    localparam int IDX_W  = (MAX_DIM > 1) ? $clog2(MAX_DIM) : 1;

    smm_state_t        state_reg, state_next;
    logic [SIZE_W-1:0] size_reg;
    logic [CNT_W-1:0]  load_cnt_reg, load_cnt_next;
    logic [IDX_W-1:0]  i_reg, i_next;
    logic [IDX_W-1:0]  j_reg, j_next;
    logic [IDX_W-1:0]  k_reg, k_next;

    logic [CNT_W-1:0]  dim;
    logic [CNT_W-1:0]  total;
    logic [IDX_W-1:0]  dim_m1;
    logic [CNT_W-1:0]  a_addr_full;
    logic [CNT_W-1:0]  b_addr_full;
    logic              last_k;
    logic              last_elem;

    // clamp the size register into 1 .. MAX_DIM
    always_comb
    begin
        priority if (size_reg == '0)
        begin
            dim = CNT_W'(1);
        end
        else if (size_reg > SIZE_W'(MAX_DIM))
        begin
            dim = CNT_W'(MAX_DIM);
        end
        else
        begin
            dim = CNT_W'(size_reg);
        end
    end

    assign total       = CNT_W'(dim * dim);
    assign dim_m1      = IDX_W'(dim - CNT_W'(1));
    assign a_addr_full = CNT_W'(dim * CNT_W'(i_reg) + CNT_W'(k_reg));
    assign b_addr_full = CNT_W'(dim * CNT_W'(k_reg) + CNT_W'(j_reg));
    assign rd_a_addr   = a_addr_full[ADDR_W-1:0];
    assign rd_b_addr   = b_addr_full[ADDR_W-1:0];
    assign wr_addr     = load_cnt_reg[ADDR_W-1:0];
    assign last_k      = (k_reg == dim_m1);
    assign last_elem   = last_k && (i_reg == dim_m1) && (j_reg == dim_m1);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= ST_LOAD;
            size_reg     <= SIZE_RESET;
            load_cnt_reg <= '0;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            load_cnt_reg <= load_cnt_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            if (cfg_wr_en)
            begin
                size_reg <= cfg_wr_data;
            end
        end
    end

    always_comb
    begin
        state_next    = state_reg;
        load_cnt_next = load_cnt_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        in_ready      = 1'b0;
        cmd           = '0;

        unique case (state_reg)
            ST_LOAD:
            begin
                in_ready   = 1'b1;
                cmd.wr_en  = in_valid;
                if (in_valid)
                begin
                    if (load_cnt_reg + CNT_W'(1) == total)
                    begin
                        load_cnt_next = '0;
                        i_next        = '0;
                        j_next        = '0;
                        k_next        = '0;
                        state_next    = ST_COMPUTE;
                    end
                    else
                    begin
                        load_cnt_next = load_cnt_reg + CNT_W'(1);
                    end
                end
            end
            ST_COMPUTE:
            begin
                // issue one product per cycle while the datapath advances
                if (advance)
                begin
                    cmd.rd_en         = 1'b1;
                    cmd.tag.first_k   = (k_reg == '0);
                    cmd.tag.last_k    = last_k;
                    cmd.tag.last_elem = last_elem;
                    if (!last_k)
                    begin
                        k_next = k_reg + IDX_W'(1);
                    end
                    else
                    begin
                        k_next = '0;
                        if (last_elem)
                        begin
                            state_next = ST_LOAD;
                        end
                        else if (j_reg == dim_m1)
                        begin
                            j_next = '0;
                            i_next = i_reg + IDX_W'(1);
                        end
                        else
                        begin
                            j_next = j_reg + IDX_W'(1);
                        end
                    end
                end
            end
            default:
            begin
                state_next = ST_LOAD;
            end
        endcase

        // a size write drops any partial load
        if (cfg_wr_en)
        begin
            load_cnt_next = '0;
        end
    end

endmodule

// File: rtl/core/smm_datapath.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// smm_datapath: element stores and multiply-accumulate pipeline
// Two element memories, a registered read, a registered multiply, an
// accumulator and an output register; the whole pipe moves on advance.
// ----------------------------------------------------------------------------
module smm_datapath
    import smm_pkg::*;
#(
    parameter int MAX_DIM   = 8,
    parameter int ELEM_BITS = 16
)
(
    input  logic                           clk,
    input  logic                           rst_n,
    input  smm_cmd_t                       cmd,
    input  logic [smm_addr_w(MAX_DIM)-1:0] wr_addr,
    input  logic [smm_addr_w(MAX_DIM)-1:0] rd_a_addr,
    input  logic [smm_addr_w(MAX_DIM)-1:0] rd_b_addr,
    input  logic [ELEM_BITS-1:0]           wr_a,
    input  logic [ELEM_BITS-1:0]           wr_b,
    output logic                           advance,
    output logic                           out_valid,
    input  logic                           out_ready,
    output logic [OUT_W-1:0]               out_elem,
    output logic                           out_last
);

    localparam int DEPTH  = MAX_DIM * MAX_DIM;
    localparam int PROD_W = 2 * ELEM_BITS;

    logic [ELEM_BITS-1:0]     left_mem  [DEPTH];
    logic [ELEM_BITS-1:0]     right_mem [DEPTH];

    logic [ELEM_BITS-1:0]     a_rd_reg;
    logic [ELEM_BITS-1:0]     b_rd_reg;
    logic                     s1_vld_reg;
    smm_tag_t                 s1_tag_reg;

    logic signed [PROD_W-1:0] prod_full;
    logic signed [OUT_W-1:0]  prod_reg;
    logic                     s2_vld_reg;
    smm_tag_t                 s2_tag_reg;

    logic [OUT_W-1:0]         acc_reg;
    logic [OUT_W-1:0]         acc_next;

    logic                     out_vld_reg;
    logic [OUT_W-1:0]         out_elem_reg;
    logic                     out_last_reg;
    logic                     emit;

    // hold the whole pipe while a result waits at the output
    assign advance = !out_vld_reg || out_ready;

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            left_mem[wr_addr]  <= wr_a;
            right_mem[wr_addr] <= wr_b;
        end
        if (cmd.rd_en && advance)
        begin
            a_rd_reg <= left_mem[rd_a_addr];
            b_rd_reg <= right_mem[rd_b_addr];
        end
    end

    assign prod_full = $signed(a_rd_reg) * $signed(b_rd_reg);
    assign acc_next  = (s2_tag_reg.first_k ? '0 : acc_reg) + OUT_W'(prod_reg);
    assign emit      = s2_vld_reg && s2_tag_reg.last_k;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_vld_reg  <= 1'b0;
            s2_vld_reg  <= 1'b0;
            out_vld_reg <= 1'b0;
        end
        else if (advance)
        begin
            s1_vld_reg  <= cmd.rd_en;
            s2_vld_reg  <= s1_vld_reg;
            out_vld_reg <= emit;
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            s1_tag_reg <= cmd.tag;
            s2_tag_reg <= s1_tag_reg;
            prod_reg   <= OUT_W'(prod_full);
            if (s2_vld_reg)
            begin
                acc_reg <= acc_next;
            end
            if (emit)
            begin
                out_elem_reg <= acc_next;
                out_last_reg <= s2_tag_reg.last_elem;
            end
        end
    end

    assign out_valid = out_vld_reg;
    assign out_elem  = out_elem_reg;
    assign out_last  = out_last_reg;

endmodule
